// File: design/token_ring_station_unit_defines.svh
// assertion macros used by the token ring station top level
`ifndef TOKEN_RING_STATION_UNIT_DEFINES_SVH
`define TOKEN_RING_STATION_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, checked outside reset
`define TRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: design/trs_pkg.sv
// types and constants of the token ring station
`timescale 1ns / 1ps

package trs_pkg;

  localparam logic [7:0] TOKEN_BYTE = 8'h31;
  localparam int unsigned HDR_LEN = 4;
  localparam int unsigned LEN_POS = 3;
  localparam logic REG_NODE_ID = 1'b0;

  typedef enum logic [1:0] {
    ACT_RING  = 2'd0,
    ACT_STORE = 2'd1,
    ACT_TOKEN = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    PH_FLAG = 3'd0,
    PH_DEST = 3'd1,
    PH_SRC  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef struct packed {
    logic        use_ram;
    logic [7:0]  byte_val;
    logic        released;
    logic [31:0] sent;
    logic [31:0] received;
  } res_t;

endpackage

// File: design/token_ring_station_unit.sv
// top level of the token ring station with source stripping
`timescale 1ns / 1ps
`include "token_ring_station_unit_defines.svh"

// Takes one item per clock while results are taken and registers each result
// in a pending stage, then the output. Ring bytes are forwarded and parsed; when
// the token arrives with a frame pending, the stored frame goes out one byte per
// received ring byte while the received bytes are stripped, and then the token
// is re-issued. The frame store is a ram of MAX_DATA+4 bytes with one write and
// one read port and registered read data: the read issued when an item is
// accepted is returned in the following cycle and registered into the output
// when the pending item moves on. The length byte is also held in a register,
// so no clearing pass is needed after reset. Store writes, token injection and
// ring bytes all run at one item per clock as long as results are taken.

module token_ring_station_unit #(
  parameter int MAX_DATA = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [8:0]  in_store_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_frame_released,
  output logic [31:0] out_sent_total,
  output logic [31:0] out_received_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_DATA + trs_pkg::HDR_LEN;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);

  logic [7:0]       node_id_r;
  trs_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       flen_r, flen_nxt;
  logic [7:0]       dseen_r, dseen_nxt;
  logic             tx_r, tx_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [PW-1:0]    total_r, total_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [31:0]      sent_r, sent_nxt;
  logic [31:0]      recv_r, recv_nxt;

  logic             p_valid_r, p_valid_nxt;
  trs_pkg::res_t    p_r, p_nxt;
  logic             out_valid_r;
  trs_pkg::res_t    out_r;

  logic             accept;
  logic             p_move;
  logic             emit;
  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;
  logic [7:0]       len_sat;
  logic [7:0]       dseen_inc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == trs_pkg::REG_NODE_ID) ? {24'd0, node_id_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == trs_pkg::REG_NODE_ID) begin
      node_id_r <= pwdata[7:0];
    end
  end

  assign p_move   = p_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !p_valid_r || p_move;
  assign accept   = in_valid && in_ready;

  assign len_sat   = (len_r > 8'(MAX_DATA)) ? 8'(MAX_DATA) : len_r;
  assign dseen_inc = dseen_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    flen_nxt  = flen_r;
    dseen_nxt = dseen_r;
    tx_nxt    = tx_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    len_nxt   = len_r;
    sent_nxt  = sent_r;
    recv_nxt  = recv_r;
    emit      = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = pos_r[AW-1:0];
    p_nxt.use_ram  = 1'b0;
    p_nxt.byte_val = in_data_byte;
    p_nxt.released = 1'b0;
    if (accept) begin
      case (trs_pkg::action_t'(in_action))
        trs_pkg::ACT_RING: begin
          emit = 1'b1;
          if (tx_r) begin
            if (pos_r < total_r) begin
              pos_nxt = pos_r + PW'(1);
              if (pos_r == PW'(trs_pkg::LEN_POS)) begin
                p_nxt.byte_val = len_r;
              end else begin
                p_nxt.use_ram = 1'b1;
                ram_re        = 1'b1;
              end
            end else begin
              tx_nxt         = 1'b0;
              pos_nxt        = '0;
              len_nxt        = 8'd0;
              phase_nxt      = trs_pkg::PH_FLAG;
              p_nxt.byte_val = trs_pkg::TOKEN_BYTE;
              p_nxt.released = 1'b1;
            end
          end else begin
            case (phase_r)
              trs_pkg::PH_DEST: begin
                if (in_data_byte == node_id_r) begin
                  recv_nxt = recv_r + 32'd1;
                end
                phase_nxt = trs_pkg::PH_SRC;
              end
              trs_pkg::PH_SRC: begin
                phase_nxt = trs_pkg::PH_LEN;
              end
              trs_pkg::PH_LEN: begin
                flen_nxt  = in_data_byte;
                dseen_nxt = 8'd0;
                phase_nxt = (in_data_byte == 8'd0) ? trs_pkg::PH_FLAG : trs_pkg::PH_DATA;
              end
              trs_pkg::PH_DATA: begin
                dseen_nxt = dseen_inc;
                if (dseen_inc == flen_r) begin
                  dseen_nxt = 8'd0;
                  phase_nxt = trs_pkg::PH_FLAG;
                end
              end
              default: begin
                if (in_data_byte == trs_pkg::TOKEN_BYTE) begin
                  phase_nxt = trs_pkg::PH_FLAG;
                  if (len_sat != 8'd0) begin
                    sent_nxt      = sent_r + 32'd1;
                    tx_nxt        = 1'b1;
                    total_nxt     = PW'(len_sat) + PW'(trs_pkg::HDR_LEN);
                    pos_nxt       = PW'(1);
                    ram_raddr     = '0;
                    ram_re        = 1'b1;
                    p_nxt.use_ram = 1'b1;
                  end
                end else begin
                  phase_nxt = trs_pkg::PH_DEST;
                end
              end
            endcase
          end
        end
        trs_pkg::ACT_STORE: begin
          if (!tx_r && {1'b0, in_store_index} < 10'(DEPTH)) begin
            ram_we = 1'b1;
            if (in_store_index == 9'(trs_pkg::LEN_POS)) begin
              len_nxt = in_data_byte;
            end
          end
        end
        trs_pkg::ACT_TOKEN: begin
          emit           = 1'b1;
          p_nxt.byte_val = trs_pkg::TOKEN_BYTE;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    p_nxt.sent     = sent_nxt;
    p_nxt.received = recv_nxt;
    if (accept && emit) begin
      p_valid_nxt = 1'b1;
    end else if (p_move) begin
      p_valid_nxt = 1'b0;
    end else begin
      p_valid_nxt = p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= trs_pkg::PH_FLAG;
      flen_r      <= 8'd0;
      dseen_r     <= 8'd0;
      tx_r        <= 1'b0;
      pos_r       <= '0;
      total_r     <= '0;
      len_r       <= 8'd0;
      sent_r      <= 32'd0;
      recv_r      <= 32'd0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      flen_r    <= flen_nxt;
      dseen_r   <= dseen_nxt;
      tx_r      <= tx_nxt;
      pos_r     <= pos_nxt;
      total_r   <= total_nxt;
      len_r     <= len_nxt;
      sent_r    <= sent_nxt;
      recv_r    <= recv_nxt;
      p_valid_r <= p_valid_nxt;
      if (p_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      p_r <= p_nxt;
    end
    if (p_move) begin
      out_r          <= p_r;
      out_r.byte_val <= p_r.use_ram ? ram_rdata : p_r.byte_val;
    end
  end

  trs_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_store_index[AW-1:0]),
    .wdata(in_data_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_out_byte       = out_r.byte_val;
  assign out_frame_released = out_r.released;
  assign out_sent_total     = out_r.sent;
  assign out_received_total = out_r.received;

  // sent bytes never run past the end of the frame
  `TRS_ASSERT_IMPL(a_pos_in_frame, clk, rst_n, tx_r, pos_r <= total_r)
  // the token release leaves a released result in flight
  `TRS_ASSERT_IMPL(a_release_result, clk, rst_n, $fell(tx_r), p_valid_r && p_r.released)
  // a stalled output keeps the in-flight item and its ram data
  `TRS_ASSERT_NEXT(a_stall_holds, clk, rst_n, p_valid_r && out_valid_r && !out_ready,
                   p_valid_r && $stable(ram_rdata))
  // seizing the token counts the frame as sent
  `TRS_ASSERT_IMPL(a_seize_counts, clk, rst_n, $rose(tx_r), sent_r == $past(sent_r) + 32'd1)

endmodule

// File: design/trs_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module trs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 259
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: test/testbench.sv
// testbench for the token ring station: directed item table, then random items checked by a predictor
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_DATA = 255;
  localparam int STORE_DEPTH = trs_pkg::HDR_LEN + MAX_DATA;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] NODE_ID_ADDR = {trs_pkg::REG_NODE_ID, 2'b00};
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 300;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        released;
    logic [31:0] sent;
    logic [31:0] received;
  } ring_out_t;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] data;
    logic [8:0] idx;
    logic       typed;
    logic       has_res;
    ring_out_t  res;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    // token with nothing pending, token injection, unused action
    '{trs_pkg::ACT_RING,  8'h31, 9'd0,   1'b1, 1'b1, '{8'h31, 1'b0, 32'd0, 32'd0}},
    '{trs_pkg::ACT_TOKEN, 8'hFF, 9'd0,   1'b1, 1'b1, '{8'h31, 1'b0, 32'd0, 32'd0}},
    '{ACT_UNUSED,         8'h00, 9'd0,   1'b1, 1'b0, '0},
    // frame addressed here with zero length
    '{trs_pkg::ACT_RING,  8'h7E, 9'd0,   1'b1, 1'b1, '{8'h7E, 1'b0, 32'd0, 32'd0}},
    '{trs_pkg::ACT_RING,  8'h00, 9'd0,   1'b1, 1'b1, '{8'h00, 1'b0, 32'd0, 32'd1}},
    '{trs_pkg::ACT_RING,  8'hFF, 9'd0,   1'b1, 1'b1, '{8'hFF, 1'b0, 32'd0, 32'd1}},
    '{trs_pkg::ACT_RING,  8'h00, 9'd0,   1'b1, 1'b1, '{8'h00, 1'b0, 32'd0, 32'd1}},
    '{trs_pkg::ACT_RING,  8'h31, 9'd0,   1'b1, 1'b1, '{8'h31, 1'b0, 32'd0, 32'd1}},
    // foreign frame carrying the token value as data
    '{trs_pkg::ACT_RING,  8'h00, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'h5A, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'h12, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'h01, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'h31, 9'd0,   1'b0, 1'b0, '0},
    // load a one byte frame, plus a write beyond the store
    '{trs_pkg::ACT_STORE, 8'h7E, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_STORE, 8'hFF, 9'd1,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_STORE, 8'h00, 9'd2,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_STORE, 8'h01, 9'd3,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_STORE, 8'hAB, 9'd4,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_STORE, 8'h55, 9'd511, 1'b0, 1'b0, '0},
    // seize, write while busy, strip and re-issue
    '{trs_pkg::ACT_RING,  8'h31, 9'd0,   1'b1, 1'b1, '{8'h7E, 1'b0, 32'd1, 32'd1}},
    '{trs_pkg::ACT_STORE, 8'h09, 9'd3,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'h00, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'hFF, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'h00, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'h00, 9'd0,   1'b0, 1'b0, '0},
    '{trs_pkg::ACT_RING,  8'h00, 9'd0,   1'b1, 1'b1, '{8'h31, 1'b1, 32'd1, 32'd1}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [7:0]  in_data_byte;
  logic [8:0]  in_store_index;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_out_byte;
  logic        out_frame_released;
  logic [31:0] out_sent_total;
  logic [31:0] out_received_total;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  token_ring_station_unit #(.MAX_DATA(MAX_DATA)) dut (.*);

  // station state as seen by the predictor
  logic [7:0]       station_addr;
  trs_pkg::phase_t  phase;
  logic [7:0]       frame_len;
  logic [7:0]       data_seen;
  logic             tx_busy;
  logic [8:0]       tx_pos;
  logic [8:0]       tx_end;
  logic [7:0]       frame_mem [0:STORE_DEPTH-1];
  bit               mem_written [0:STORE_DEPTH-1];
  logic [31:0]      sent_count;
  logic [31:0]      recv_count;

  ring_out_t   expected_q [$];
  ring_out_t   want;
  int          errors;
  int          items_sent;
  int          cycles;
  bit          sender_idles;
  bit          recv_idles;
  bit          long_hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void station_reset();
    station_addr = '0;
    phase = trs_pkg::PH_FLAG;
    frame_len = '0;
    data_seen = '0;
    tx_busy = 1'b0;
    tx_pos = '0;
    tx_end = '0;
    sent_count = '0;
    recv_count = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      frame_mem[i] = '0;
      mem_written[i] = 1'b0;
    end
  endfunction

  function automatic int unsigned pending_len();
    return (frame_mem[trs_pkg::LEN_POS] > MAX_DATA) ? MAX_DATA : frame_mem[trs_pkg::LEN_POS];
  endfunction

  // true unless a token now would send a store entry never written
  function automatic bit seize_safe();
    int unsigned len;
    len = pending_len();
    if (len == 0) return 1'b1;
    for (int i = 0; i < len + trs_pkg::HDR_LEN; i++) begin
      if (!mem_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit station_step(input logic [1:0] act, input logic [7:0] b,
                                      input logic [8:0] idx, output ring_out_t r);
    int unsigned len;
    r = '0;
    case (act)
      trs_pkg::ACT_STORE: begin
        if (!tx_busy && idx < STORE_DEPTH) begin
          frame_mem[idx] = b;
          mem_written[idx] = 1'b1;
        end
        return 1'b0;
      end
      trs_pkg::ACT_TOKEN: begin
        r = '{trs_pkg::TOKEN_BYTE, 1'b0, sent_count, recv_count};
        return 1'b1;
      end
      trs_pkg::ACT_RING: begin
        if (tx_busy) begin
          // ring byte is stripped, own frame goes out instead
          if (tx_pos < tx_end) begin
            r.byte_val = frame_mem[tx_pos];
            tx_pos = tx_pos + 1'b1;
          end else begin
            tx_busy = 1'b0;
            tx_pos = '0;
            frame_mem[trs_pkg::LEN_POS] = '0;
            phase = trs_pkg::PH_FLAG;
            r.byte_val = trs_pkg::TOKEN_BYTE;
            r.released = 1'b1;
          end
        end else begin
          r.byte_val = b;
          case (phase)
            trs_pkg::PH_DEST: begin
              if (b == station_addr) recv_count = recv_count + 1;
              phase = trs_pkg::PH_SRC;
            end
            trs_pkg::PH_SRC: phase = trs_pkg::PH_LEN;
            trs_pkg::PH_LEN: begin
              frame_len = b;
              data_seen = '0;
              phase = (b == 8'd0) ? trs_pkg::PH_FLAG : trs_pkg::PH_DATA;
            end
            trs_pkg::PH_DATA: begin
              data_seen = data_seen + 1'b1;
              if (data_seen == frame_len) begin
                data_seen = '0;
                phase = trs_pkg::PH_FLAG;
              end
            end
            default: begin
              if (b == trs_pkg::TOKEN_BYTE) begin
                len = pending_len();
                phase = trs_pkg::PH_FLAG;
                if (len > 0) begin
                  sent_count = sent_count + 1;
                  tx_busy = 1'b1;
                  tx_end = 9'(len + trs_pkg::HDR_LEN);
                  tx_pos = 9'd1;
                  r.byte_val = frame_mem[0];
                end
              end else begin
                phase = trs_pkg::PH_DEST;
              end
            end
          endcase
        end
        r.sent = sent_count;
        r.received = recv_count;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic offer_item(input logic [1:0] act, input logic [7:0] b, input logic [8:0] idx);
    bit took;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_data_byte <= b;
    in_store_index <= idx;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic apply_item(input logic [1:0] act, input logic [7:0] b, input logic [8:0] idx);
    ring_out_t r;
    if (act == trs_pkg::ACT_RING && !tx_busy && phase == trs_pkg::PH_FLAG &&
        b == trs_pkg::TOKEN_BYTE && !seize_safe())
      b = trs_pkg::TOKEN_BYTE ^ 8'h80;
    offer_item(act, b, idx);
    if (station_step(act, b, idx, r)) expected_q.push_back(r);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    // store writes give no result but may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node_id(input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= NODE_ID_ADDR;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    station_addr = v;
  endtask

  task automatic random_scenario();
    int pick;
    int n;
    int len;
    logic [7:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // load a frame, now and then with a hole or a stray write
      n = $urandom_range(0, 99);
      if (n == 99) len = MAX_DATA;
      else if (n >= 97) len = $urandom_range(65, MAX_DATA);
      else if (n >= 85) len = $urandom_range(9, 64);
      else len = $urandom_range(1, 8);
      for (int i = 0; i < len + trs_pkg::HDR_LEN; i++) begin
        if ($urandom_range(0, 59) == 0) continue;
        v = (i == trs_pkg::LEN_POS) ? 8'(len) : 8'($urandom_range(0, 255));
        apply_item(trs_pkg::ACT_STORE, v, 9'(i));
      end
      if ($urandom_range(0, 9) == 0)
        apply_item(trs_pkg::ACT_STORE, 8'($urandom_range(0, 255)),
                   9'($urandom_range(STORE_DEPTH, 511)));
    end else if (pick < 55) begin
      // frame passing by on the ring
      v = 8'($urandom_range(0, 255));
      if (v == trs_pkg::TOKEN_BYTE) v = ~v;
      apply_item(trs_pkg::ACT_RING, v, 9'($urandom_range(0, 511)));
      v = $urandom_range(0, 1) ? station_addr : 8'($urandom_range(0, 255));
      apply_item(trs_pkg::ACT_RING, v, 9'($urandom_range(0, 511)));
      apply_item(trs_pkg::ACT_RING, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      n = $urandom_range(0, 99);
      len = (n < 15) ? 0 : (n < 95) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      apply_item(trs_pkg::ACT_RING, 8'(len), 9'($urandom_range(0, 511)));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 49) == 0) break;
        apply_item(trs_pkg::ACT_RING, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      end
    end else if (pick < 75) begin
      // token arrives; if seized, feed ring bytes until it is re-issued
      apply_item(trs_pkg::ACT_RING, trs_pkg::TOKEN_BYTE, 9'($urandom_range(0, 511)));
      while (tx_busy) begin
        n = $urandom_range(0, 19);
        if (n == 0)
          apply_item(trs_pkg::ACT_STORE, 8'($urandom_range(0, 255)),
                     9'($urandom_range(0, STORE_DEPTH - 1)));
        else if (n == 1)
          apply_item(trs_pkg::ACT_TOKEN, 8'($urandom_range(0, 255)),
                     9'($urandom_range(0, 511)));
        else
          apply_item(trs_pkg::ACT_RING, 8'($urandom_range(0, 255)),
                     9'($urandom_range(0, 511)));
      end
    end else if (pick < 85) begin
      apply_item(trs_pkg::ACT_TOKEN, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
    end else if (pick < 90) begin
      apply_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
    end else begin
      repeat ($urandom_range(1, 5))
        apply_item(trs_pkg::ACT_RING, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
    end
  endtask

  task automatic report(input string what, input logic [31:0] exp_val, input logic [31:0] act_val);
    $display("%0t: %s expected %0h, got %0h", $time, what, exp_val, act_val);
    errors++;
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got out_byte %0h",
                 $time, out_out_byte);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_out_byte !== want.byte_val)
          report("out_byte", 32'(want.byte_val), 32'(out_out_byte));
        if (out_frame_released !== want.released)
          report("frame_released", 32'(want.released), 32'(out_frame_released));
        if (out_sent_total !== want.sent) report("sent_total", want.sent, out_sent_total);
        if (out_received_total !== want.received)
          report("received_total", want.received, out_received_total);
      end
    end
  end

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (recv_idles && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : main_flow
    ring_out_t r;
    bit has;
    bit paused;
    bit idle_phase;
    int target;
    logic [7:0] addr_val;
    errors = 0;
    items_sent = 0;
    sender_idles = 1'b0;
    recv_idles = 1'b0;
    long_hold_req = 1'b0;
    paused = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= trs_pkg::ACT_RING;
    in_data_byte <= '0;
    in_store_index <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    station_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_node_id(8'h00);

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_item(DIRECTED[i].act, DIRECTED[i].data, DIRECTED[i].idx);
      has = station_step(DIRECTED[i].act, DIRECTED[i].data, DIRECTED[i].idx, r);
      if (DIRECTED[i].typed) begin
        if (DIRECTED[i].has_res) expected_q.push_back(DIRECTED[i].res);
      end else if (has) begin
        expected_q.push_back(r);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: addr_val = 8'hFF;
        2: addr_val = trs_pkg::TOKEN_BYTE;
        PHASES - 1: addr_val = 8'h00;
        default: addr_val = 8'($urandom_range(0, 255));
      endcase
      write_node_id(addr_val);
      idle_phase = (p != PHASES - 1);
      target = items_sent + ITEMS_PER_PHASE;
      if (p == 1) begin
        // receiver holds off while ring bytes keep coming
        long_hold_req = 1'b1;
        sender_idles = 1'b0;
        repeat (60)
          apply_item(trs_pkg::ACT_RING, 8'($urandom_range(0, 255)),
                     9'($urandom_range(0, 511)));
      end
      while (items_sent < target) begin
        if (p == 2 && !paused && items_sent >= target - ITEMS_PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        sender_idles = idle_phase && $urandom_range(0, 3) != 0;
        recv_idles = idle_phase && $urandom_range(0, 3) != 0;
        random_scenario();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
